>>> rtl/tekd_pkg.sv
// Package: shared types and constants for the terminal escape key decoder.
`default_nettype none

package tekd_pkg;

    typedef enum logic [1:0] {
        OP_BYTE   = 2'd0,
        OP_TICK   = 2'd1,
        OP_END    = 2'd2,
        OP_CANCEL = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_CSI  = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [13:0] csi_parameter;
        logic        after_separator;
        logic [7:0]  sequence_length;
        logic [31:0] idle_count;
        logic        swallow_next_lf;
    } dec_state_t;

    localparam int unsigned KeyW = 10;
    typedef logic signed [KeyW-1:0] key_t;

    localparam key_t K_EOF    = -10'sd1;
    localparam key_t K_CTRL_C = 10'sd3;
    localparam key_t K_LF     = 10'sd10;
    localparam key_t K_ESC    = 10'sd27;
    localparam key_t K_UP     = 10'sd256;
    localparam key_t K_DOWN   = 10'sd257;
    localparam key_t K_LEFT   = 10'sd258;
    localparam key_t K_RIGHT  = 10'sd259;
    localparam key_t K_HOME   = 10'sd260;
    localparam key_t K_END    = 10'sd261;
    localparam key_t K_DELETE = 10'sd262;
    localparam key_t K_PGUP   = 10'sd263;
    localparam key_t K_PGDN   = 10'sd264;

    // Configuration register indices
    localparam logic CFG_IDLE_TIMEOUT = 1'b0;
    localparam logic CFG_MAX_SEQ      = 1'b1;

    localparam logic [31:0] IDLE_TIMEOUT_RST = 32'd10000;
    localparam logic [7:0]  MAX_SEQ_RST      = 8'd24;

endpackage

`default_nettype wire

>>> rtl/terminal_escape_key_decoder_top.sv
// Top level: terminal escape key decoder with input and result registers.
//
// Usage
//   Input channel (in_valid/in_ready, op, rx_byte): one terminal event per beat,
//   a received byte, an idle tick, end of input or a cancel request.
//   Output channel (out_valid/out_ready, key_code): zero or one key per event,
//   in event order. Events that produce no key (ESC, CSI body bytes, ticks
//   below the timeout, a swallowed LF) simply update the decoder state.
//   Config port (cfg_write, cfg_index, cfg_data): index 0 idle timeout in
//   ticks, index 1 max bytes after the CSI introducer. Write only while idle.
// Timing
//   A beat lands in the input register; one decode step then loads the
//   result register. One event per cycle unless out_ready stalls, set by
//   the combinational decode step (one 32-bit increment and compare on the
//   idle counter in the worst path).
// Stalls
//   When out_ready is low with a key held, the input register holds its beat
//   and in_ready drops only once that register is full as well.
// Reset
//   rst_n clears the decoder to idle, both registers to empty, the timeout
//   to 10000 ticks and the sequence limit to 24 bytes.
`default_nettype none

module terminal_escape_key_decoder_top
    import tekd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  rx_byte,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic signed [9:0] key_code,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

    // Input register stage
    logic        s1_valid_reg;
    logic [1:0]  s1_op_reg;
    logic [7:0]  s1_byte_reg;

    // Result register
    logic        out_valid_reg;
    key_t        key_reg;

    // Decoder state and configuration
    dec_state_t  state_reg;
    dec_state_t  state_next;
    logic [31:0] idle_timeout_reg;
    logic [7:0]  max_seq_reg;

    logic        dec_fire;
    key_t        dec_key;
    logic        s1_advance;

    // The event in the input register is decoded once the result slot is free
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign out_valid  = out_valid_reg;
    assign key_code   = key_reg;

    tekd_decode u_decode (
        .cur                (state_reg),
        .op                 (op_t'(s1_op_reg)),
        .rx_byte            (s1_byte_reg),
        .idle_timeout_ticks (idle_timeout_reg),
        .max_sequence_bytes (max_seq_reg),
        .nxt                (state_next),
        .fire               (dec_fire),
        .key_code           (dec_key)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_op_reg   <= op;
            s1_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_IDLE, default: '0};
        end
        else if (s1_advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= dec_fire;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && dec_fire)
        begin
            key_reg <= dec_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg <= IDLE_TIMEOUT_RST;
            max_seq_reg      <= MAX_SEQ_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data;
                CFG_MAX_SEQ:      max_seq_reg      <= cfg_data[7:0];
                default:          max_seq_reg      <= max_seq_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/tekd_decode.sv
// Combinational decode step: next decoder state and optional key for one beat.
`default_nettype none

module tekd_decode
    import tekd_pkg::*;
(
    input  dec_state_t  cur,
    input  op_t         op,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] idle_timeout_ticks,
    input  logic [7:0]  max_sequence_bytes,
    output dec_state_t  nxt,
    output logic        fire,
    output key_t        key_code
);

    localparam logic [7:0] CH_CTRL_C = 8'h03;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] FINAL_LO  = 8'h40;
    localparam logic [7:0] FINAL_HI  = 8'h7E;
    localparam logic [13:0] PARAM_CAP = 14'd1000;

    function automatic key_t final_key(input logic [7:0] c, input logic [13:0] p);
        key_t k;
        k = K_ESC;
        unique case (c)
            8'h41: k = K_UP;     // 'A'
            8'h42: k = K_DOWN;   // 'B'
            8'h43: k = K_RIGHT;  // 'C'
            8'h44: k = K_LEFT;   // 'D'
            8'h48: k = K_HOME;   // 'H'
            8'h46: k = K_END;    // 'F'
            8'h7E:               // '~' takes the numeric parameter
            begin
                unique case (p)
                    14'd1, 14'd7: k = K_HOME;
                    14'd4, 14'd8: k = K_END;
                    14'd3:        k = K_DELETE;
                    14'd5:        k = K_PGUP;
                    14'd6:        k = K_PGDN;
                    default:      k = K_ESC;
                endcase
            end
            default: k = K_ESC;
        endcase
        return k;
    endfunction

    logic [31:0] idle_inc;
    logic [8:0]  len_inc;
    logic [13:0] param_x10;
    logic [13:0] digit;
    logic        drop_lf;

    assign idle_inc  = cur.idle_count + 32'd1;
    assign len_inc   = {1'b0, cur.sequence_length} + 9'd1;
    assign param_x10 = {cur.csi_parameter[10:0], 3'b000} + {cur.csi_parameter[12:0], 1'b0};
    assign digit     = {10'd0, rx_byte[3:0]};
    assign drop_lf   = cur.swallow_next_lf && (rx_byte == CH_LF);

    always_comb
    begin
        nxt      = cur;
        fire     = 1'b0;
        key_code = K_ESC;

        unique case (op)
            OP_CANCEL:
            begin
                fire     = 1'b1;
                key_code = K_CTRL_C;
            end
            OP_END:
            begin
                fire     = 1'b1;
                key_code = K_EOF;
            end
            OP_TICK:
            begin
                if (cur.phase != PH_IDLE)
                begin
                    nxt.idle_count = idle_inc;
                    if (idle_inc >= idle_timeout_ticks)
                    begin
                        fire     = 1'b1;
                        key_code = K_ESC;
                    end
                end
            end
            OP_BYTE:
            begin
                nxt.idle_count      = 32'd0;
                nxt.swallow_next_lf = 1'b0;
                if (!drop_lf)
                begin
                    if (rx_byte == CH_CTRL_C)
                    begin
                        fire     = 1'b1;
                        key_code = K_CTRL_C;
                    end
                    else
                    begin
                        unique case (cur.phase)
                            PH_IDLE:
                            begin
                                if (rx_byte == CH_ESC)
                                    nxt.phase = PH_ESC;
                                else if (rx_byte == CH_CR)
                                begin
                                    nxt.swallow_next_lf = 1'b1;
                                    fire                = 1'b1;
                                    key_code            = K_LF;
                                end
                                else
                                begin
                                    fire     = 1'b1;
                                    key_code = key_t'({2'b00, rx_byte});
                                end
                            end
                            PH_ESC:
                            begin
                                if (rx_byte == CH_LBRK || rx_byte == CH_O)
                                    nxt.phase = PH_CSI;
                                else
                                begin
                                    fire     = 1'b1;
                                    key_code = K_ESC;
                                end
                            end
                            PH_CSI:
                            begin
                                if (len_inc > {1'b0, max_sequence_bytes})
                                begin
                                    fire     = 1'b1;
                                    key_code = K_ESC;
                                end
                                else
                                begin
                                    nxt.sequence_length = len_inc[7:0];
                                    if (rx_byte >= CH_0 && rx_byte <= CH_9)
                                    begin
                                        if (!cur.after_separator
                                            && cur.csi_parameter < PARAM_CAP)
                                            nxt.csi_parameter = param_x10 + digit;
                                    end
                                    else if (rx_byte == CH_SEMI)
                                        nxt.after_separator = 1'b1;
                                    else if (rx_byte >= FINAL_LO && rx_byte <= FINAL_HI)
                                    begin
                                        fire     = 1'b1;
                                        key_code = final_key(rx_byte, cur.csi_parameter);
                                    end
                                end
                            end
                            default:
                            begin
                                fire     = 1'b1;
                                key_code = K_ESC;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                fire     = 1'b0;
                key_code = K_ESC;
            end
        endcase

        // Any emitted key closes the sequence; swallow flag survives
        if (fire)
        begin
            nxt.phase           = PH_IDLE;
            nxt.csi_parameter   = 14'd0;
            nxt.after_separator = 1'b0;
            nxt.sequence_length = 8'd0;
            nxt.idle_count      = 32'd0;
        end
    end

endmodule

`default_nettype wire

>>> verif/key_stream_checker.sv
// Checker: tracks decoder state from accepted beats and compares predicted keys with the output.
`timescale 1ns / 100ps

module key_stream_checker
    import tekd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic [1:0]        op,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic signed [9:0] key_code,
    input  wire logic              cfg_write,
    input  wire logic              cfg_index,
    input  wire logic [31:0]       cfg_data,
    output int                     fail_count,
    output int                     pending_keys
);

    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_ESC = 8'h1B;

    logic [31:0] idle_limit;
    logic [7:0]  seq_limit;
    phase_t      dec_phase;
    logic [13:0] csi_param;
    logic        after_sep;
    logic [7:0]  seq_len;
    logic [31:0] idle_cnt;
    logic        swallow_lf;
    key_t        expected_keys[$];
    key_t        oldest;

    // Every key closes the sequence; the LF swallow flag survives it.
    function automatic void end_key(input key_t k);
        expected_keys.push_back(k);
        dec_phase = PH_IDLE;
        csi_param = '0;
        after_sep = 1'b0;
        seq_len   = '0;
        idle_cnt  = '0;
    endfunction

    function automatic void decode_event(input op_t ev, input logic [7:0] b);
        int   len;
        key_t fin;
        case (ev)
            OP_CANCEL: end_key(K_CTRL_C);
            OP_END:    end_key(K_EOF);
            OP_TICK:
                if (dec_phase != PH_IDLE)
                begin
                    idle_cnt = idle_cnt + 32'd1;
                    if (idle_cnt >= idle_limit) end_key(K_ESC);
                end
            default:
            begin
                idle_cnt = '0;
                if (swallow_lf && b == CH_LF)
                begin
                    swallow_lf = 1'b0;
                end
                else
                begin
                    swallow_lf = 1'b0;
                    if (b == CH_ETX)
                    begin
                        end_key(K_CTRL_C);
                    end
                    else if (dec_phase == PH_IDLE)
                    begin
                        if (b == CH_ESC)
                        begin
                            dec_phase = PH_ESC;
                        end
                        else if (b == CH_CR)
                        begin
                            swallow_lf = 1'b1;
                            end_key(K_LF);
                        end
                        else
                        begin
                            end_key(key_t'({2'b00, b}));
                        end
                    end
                    else if (dec_phase == PH_ESC)
                    begin
                        if (b == "[" || b == "O") dec_phase = PH_CSI;
                        else end_key(K_ESC);
                    end
                    else
                    begin
                        len = int'(seq_len) + 1;
                        if (len > int'(seq_limit))
                        begin
                            end_key(K_ESC);
                        end
                        else
                        begin
                            seq_len = (len > 255) ? 8'd255 : 8'(len);
                            if (b >= "0" && b <= "9")
                            begin
                                // parameter stops growing once it reaches 1000
                                if (!after_sep && csi_param < 14'd1000)
                                    csi_param = 14'(csi_param * 10 + (b - "0"));
                            end
                            else if (b == ";")
                            begin
                                after_sep = 1'b1;
                            end
                            else if (b >= 8'h40 && b <= 8'h7E)
                            begin
                                case (b)
                                    "A":     fin = K_UP;
                                    "B":     fin = K_DOWN;
                                    "C":     fin = K_RIGHT;
                                    "D":     fin = K_LEFT;
                                    "H":     fin = K_HOME;
                                    "F":     fin = K_END;
                                    "~":
                                    begin
                                        if (csi_param == 14'd1 || csi_param == 14'd7)
                                            fin = K_HOME;
                                        else if (csi_param == 14'd4 || csi_param == 14'd8)
                                            fin = K_END;
                                        else if (csi_param == 14'd3)
                                            fin = K_DELETE;
                                        else if (csi_param == 14'd5)
                                            fin = K_PGUP;
                                        else if (csi_param == 14'd6)
                                            fin = K_PGDN;
                                        else
                                            fin = K_ESC;
                                    end
                                    default: fin = K_ESC;
                                endcase
                                end_key(fin);
                            end
                        end
                    end
                end
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit = IDLE_TIMEOUT_RST;
            seq_limit  = MAX_SEQ_RST;
            dec_phase  = PH_IDLE;
            csi_param  = '0;
            after_sep  = 1'b0;
            seq_len    = '0;
            idle_cnt   = '0;
            swallow_lf = 1'b0;
            expected_keys.delete();
            fail_count = 0;
            pending_keys <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_IDLE_TIMEOUT) idle_limit = cfg_data;
                else seq_limit = cfg_data[7:0];
            end
            // an output beat can never stem from the input beat of the same edge
            if (out_valid && out_ready)
            begin
                if (expected_keys.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected key, expected none, actual %0d",
                             $time, key_code);
                end
                else
                begin
                    oldest = expected_keys.pop_front();
                    if (key_code !== oldest)
                    begin
                        fail_count++;
                        $display("%0t: key mismatch, expected %0d, actual %0d",
                                 $time, oldest, key_code);
                    end
                end
            end
            if (in_valid && in_ready) decode_event(op_t'(op), rx_byte);
            pending_keys <= expected_keys.size();
        end
    end

endmodule

>>> verif/tb_top.sv
// Testbench top: drives terminal events and limit settings into the key decoder.
`timescale 1ns / 100ps

module tb_top;

    import tekd_pkg::*;

    // Control characters the stimulus needs by name
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_ESC = 8'h1B;

    // The CSI finals that map to real keys, one byte each
    localparam logic [55:0] CSI_FINALS = "ABCDHF~";

    localparam int PHASE_BEATS  = 275;  // counted beats per limit setting
    localparam int NUM_SETTINGS = 6;
    localparam int DRAIN_CYCLES = 8;    // two-stage pipe, plus margin
    localparam int LONG_HOLD    = 400;  // receiver hold-off, fills the pipe

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [1:0]        op        = OP_BYTE;
    logic [7:0]        rx_byte   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic signed [9:0] key_code;
    logic              cfg_write = 1'b0;
    logic              cfg_index = CFG_IDLE_TIMEOUT;
    logic [31:0]       cfg_data  = '0;

    int fail_count;
    int pending_keys;

    // Stimulus bookkeeping, shared with the receiver process
    int cfg_set    = -1;
    int beats_sent = 0;
    bit no_gaps    = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    terminal_escape_key_decoder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .key_code  (key_code),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    key_stream_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .key_code     (key_code),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending_keys (pending_keys)
    );

    // One event beat. An optional idle gap goes first; valid is only
    // lowered when there is a gap, so back-to-back beats keep it high.
    // Returns at the edge that accepts the beat.
    task automatic send_event(input op_t ev, input logic [7:0] b);
        int roll;
        int gap;
        roll = $urandom_range(99);
        if (no_gaps || roll < 55) gap = 0;
        else if (roll < 88) gap = $urandom_range(1, 3);
        else if (roll < 98) gap = $urandom_range(4, 12);
        else gap = $urandom_range(20, 60);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= ev;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        // ticks are often ignored outright, so they do not count
        if (ev != OP_TICK) beats_sent++;
    endtask

    // Stop offering beats, wait for every predicted key, then let the
    // pipe settle in case the last beats produced no key at all.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_keys != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes both limits on consecutive edges; only called while idle.
    // Upper data bits of the byte limit are junk on purpose.
    task automatic set_limits(input logic [31:0] ticks, input logic [7:0] bytes);
        cfg_write <= 1'b1;
        cfg_index <= CFG_IDLE_TIMEOUT;
        cfg_data  <= ticks;
        @(posedge clk);
        cfg_index <= CFG_MAX_SEQ;
        cfg_data  <= {24'($urandom), bytes};
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // One random stretch of traffic. Mostly well-formed escape sequences
    // with random content, with CR/LF pairs, plain bytes and some noise.
    task automatic send_pattern();
        int kind;
        int n;
        int i;
        int roll;
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            send_event(OP_BYTE, CH_ESC);
            send_event(OP_BYTE, ($urandom_range(3) != 0) ? 8'("[") : 8'("O"));
            // single digits most often so that the tilde keys get hit
            roll = $urandom_range(9);
            n = (roll < 5) ? 1 : (roll < 7) ? 0 : $urandom_range(2, 5);
            for (i = 0; i < n; i++)
            begin
                send_event(OP_BYTE, 8'("0" + $urandom_range(9)));
                if ($urandom_range(11) == 0) send_event(OP_TICK, 8'($urandom));
            end
            if ($urandom_range(3) == 0)
            begin
                send_event(OP_BYTE, ";");
                n = $urandom_range(0, 2);
                for (i = 0; i < n; i++) send_event(OP_BYTE, 8'("0" + $urandom_range(9)));
            end
            roll = $urandom_range(9);
            if (roll == 0) send_event(OP_BYTE, 8'($urandom_range(8'h20, 8'h3F)));
            else if (roll == 1) send_event(OP_BYTE, 8'($urandom));
            roll = $urandom_range(9);
            if (roll < 7) send_event(OP_BYTE, CSI_FINALS[8 * $urandom_range(6) +: 8]);
            else if (roll < 9) send_event(OP_BYTE, 8'($urandom_range(8'h40, 8'h7E)));
            else send_event(OP_BYTE, 8'($urandom));
        end
        else if (kind < 50)
        begin
            // lone escape: wait it out, or break it with a stray byte
            send_event(OP_BYTE, CH_ESC);
            if ($urandom_range(9) < 3)
            begin
                send_event(OP_BYTE, 8'($urandom));
            end
            else
            begin
                if ($urandom_range(1) != 0) send_event(OP_BYTE, "[");
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++) send_event(OP_TICK, 8'($urandom));
            end
        end
        else if (kind < 60)
        begin
            send_event(OP_BYTE, CH_CR);
            send_event(OP_BYTE, ($urandom_range(3) != 0) ? CH_LF : 8'($urandom));
        end
        else if (kind < 80)
        begin
            send_event(OP_BYTE, 8'($urandom));
        end
        else if (kind < 85)
        begin
            send_event(($urandom_range(1) != 0) ? OP_CANCEL : OP_END, 8'($urandom));
        end
        else if (kind < 90)
        begin
            send_event(OP_TICK, 8'($urandom));
        end
        else
        begin
            send_event(op_t'($urandom_range(3)), 8'($urandom));
        end
    endtask

    // Receiver: random ready pattern with mostly short stalls, a few long
    // ones and stretches of constant ready. Once, during the fourth limit
    // setting, it holds off long enough for the sender to back up.
    initial
    begin : receiver
        int  roll;
        int  stretch;
        bit  held_long;
        held_long = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            roll = $urandom_range(99);
            if (!held_long && cfg_set == 3)
            begin
                held_long = 1'b1;
                out_ready <= 1'b0;
                stretch = LONG_HOLD;
            end
            else if (roll < 15)
            begin
                out_ready <= 1'b1;
                stretch = $urandom_range(20, 80);
            end
            else if (roll < 65)
            begin
                out_ready <= 1'b1;
                stretch = $urandom_range(1, 6);
            end
            else if (roll < 95)
            begin
                out_ready <= 1'b0;
                stretch = $urandom_range(1, 3);
            end
            else
            begin
                out_ready <= 1'b0;
                stretch = $urandom_range(10, 40);
            end
            repeat (stretch) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        logic [31:0] ticks;
        logic [7:0]  bytes;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats under the reset limits
        send_event(OP_BYTE, 8'h00);
        send_event(OP_BYTE, 8'hFF);
        send_event(OP_BYTE, CH_CR);          // gives LF and arms the swallow
        send_event(OP_BYTE, CH_LF);          // swallowed, no key
        send_event(OP_BYTE, CH_ETX);         // Ctrl-C
        send_event(OP_CANCEL, 8'hA5);
        send_event(OP_END, 8'h5A);
        send_event(OP_TICK, 8'h00);          // outside a sequence: ignored
        send_event(OP_BYTE, CH_ESC);
        send_event(OP_BYTE, "x");            // not an introducer: lone ESC
        send_event(OP_BYTE, CH_ESC);
        send_event(OP_BYTE, "O");
        send_event(OP_BYTE, "A");            // up arrow
        // parameter stops growing past 1000, then an unknown tilde code
        send_event(OP_BYTE, CH_ESC);
        send_event(OP_BYTE, "[");
        send_event(OP_BYTE, "1");
        send_event(OP_BYTE, "2");
        send_event(OP_BYTE, "3");
        send_event(OP_BYTE, "4");
        send_event(OP_BYTE, "5");
        send_event(OP_BYTE, "~");
        wait_idle();

        // Zero limits: first tick times out, first CSI byte is overlong
        set_limits(32'd0, 8'd0);
        send_event(OP_BYTE, CH_ESC);
        send_event(OP_TICK, 8'h00);
        send_event(OP_BYTE, CH_ESC);
        send_event(OP_BYTE, "[");
        send_event(OP_BYTE, "A");

        // Random traffic across a spread of limit settings
        for (int k = 0; k < NUM_SETTINGS; k++)
        begin
            wait_idle();
            case (k)
                0:
                begin
                    ticks = IDLE_TIMEOUT_RST;
                    bytes = MAX_SEQ_RST;
                end
                1:
                begin
                    ticks = 32'd1;
                    bytes = 8'd1;
                end
                2:
                begin
                    ticks = 32'd0;
                    bytes = 8'd0;
                end
                3:
                begin
                    ticks = 32'd3;
                    bytes = 8'd255;
                end
                4:
                begin
                    ticks = 32'hFFFF_FFFF;
                    bytes = 8'd2;
                end
                default:
                begin
                    ticks = 32'd2;
                    bytes = 8'd6;
                end
            endcase
            set_limits(ticks, bytes);
            // one setting runs with the sender never idling
            no_gaps    = (k == 4);
            cfg_set    = k;
            beats_sent = 0;
            while (beats_sent < PHASE_BEATS) send_pattern();
        end

        wait_idle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Far beyond the slowest legal run
    initial
    begin : watchdog
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
